// ===== sv/ffca_pkg.sv =====
// Package for the first-fit chunk allocator.
// Holds heap constants, table entry type and result codes; no dependencies.
package ffca_pkg;

  localparam int HEAP_BYTES   = 1048576;
  localparam int PAGE_BYTES   = 1024;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_CHUNKS   = 64;

  localparam int ADDR_W = 20;
  localparam int NEED_W = ADDR_W + 1;
  localparam int IDX_W  = $clog2(MAX_CHUNKS);
  localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT     = 2'd1;
  localparam logic [1:0] STATUS_BAD_OFFSET = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
    logic              busy;
  } entry_t;

endpackage

// ===== sv/ffca_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffca_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/first_fit_chunk_allocator.sv =====
// First-fit chunk allocator top level with its sequencer.
// Depends on ffca_pkg and ffca_ram (chunk table storage).
//
// The chunk table lives in one RAM and is walked one entry per cycle.
// After reset the block writes the initial free chunk in ST_INIT.
// An allocate scans entries until the first fitting free chunk; a split
// then moves every later entry up by one, one entry per cycle, and writes
// the new free remainder. Scan and move together visit N entries, N being
// the current chunk count. A release scans for its chunk and, when the
// successor is free, merges and moves the later entries down one per cycle.
// The single RAM port pair sets the pace of the walk. The result passes
// through ST_DONE, which waits while an earlier result is still held, before
// it is offered; the block is ready again in the same cycle as the result is
// offered, and a new request is taken while that result waits.
module first_fit_chunk_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic [ffca_pkg::ADDR_W-1:0] request_bytes_i,
  input  logic [ffca_pkg::ADDR_W-1:0] release_offset_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ffca_pkg::ADDR_W-1:0] data_offset_o,
  output logic [1:0]                 status_o
);

  localparam int AW = ffca_pkg::ADDR_W;
  localparam int NW = ffca_pkg::NEED_W;
  localparam int IW = ffca_pkg::IDX_W;
  localparam int CW = ffca_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CHECK,
    ST_SHIFT_UP,
    ST_INSERT,
    ST_MERGE_CHK,
    ST_SHIFT_DN,
    ST_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     total_q, total_d;
  logic              mode_q, mode_d;
  logic [NW-1:0]     need_q, need_d;
  logic [AW-1:0]     offset_q, offset_d;
  logic [AW-1:0]     cur_start_q, cur_start_d;
  logic [AW-1:0]     cur_len_q, cur_len_d;
  logic [AW-1:0]     new_start_q, new_start_d;
  logic [AW-1:0]     new_len_q, new_len_d;
  logic [AW-1:0]     res_offset_q, res_offset_d;
  logic [1:0]        res_status_q, res_status_d;
  logic              out_valid_q, out_valid_d;
  logic [AW-1:0]     data_offset_q, data_offset_d;
  logic [1:0]        status_q, status_d;

  logic              we;
  logic [IW-1:0]     waddr;
  ffca_pkg::entry_t  wdata;
  logic [IW-1:0]     raddr;
  ffca_pkg::entry_t  rdata;

  logic [NW-1:0]     len_ext;
  logic [NW-1:0]     diff;
  logic              fit;
  logic              split;
  logic              hit;
  logic              last;
  logic [NW-1:0]     data_sum;
  logic [NW+1:0]     merge_sum;
  logic [NW+1:0]     split_sum;

  ffca_ram #(
    .Width($bits(ffca_pkg::entry_t)),
    .Depth(ffca_pkg::MAX_CHUNKS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    len_ext   = {1'b0, rdata.length};
    diff      = len_ext - need_q;
    fit       = !rdata.busy && (len_ext >= need_q);
    split     = (diff >= NW'(ffca_pkg::HEADER_BYTES)) && (len_ext != need_q);
    data_sum  = {1'b0, rdata.start} + NW'(ffca_pkg::HEADER_BYTES);
    hit       = (data_sum == {1'b0, offset_q});
    last      = ((CW'(idx_q) + CW'(1)) >= total_q);
    split_sum = (NW+2)'(rdata.start) + (NW+2)'(ffca_pkg::HEADER_BYTES) + (NW+2)'(need_q);
    merge_sum = (NW+2)'(cur_len_q) + (NW+2)'(rdata.length)
                + (NW+2)'(ffca_pkg::HEADER_BYTES);
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    ptr_d         = ptr_q;
    total_d       = total_q;
    mode_d        = mode_q;
    need_d        = need_q;
    offset_d      = offset_q;
    cur_start_d   = cur_start_q;
    cur_len_d     = cur_len_q;
    new_start_d   = new_start_q;
    new_len_d     = new_len_q;
    res_offset_d  = res_offset_q;
    res_status_d  = res_status_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    data_offset_d = data_offset_q;
    status_d      = status_q;
    we            = 1'b0;
    waddr         = idx_q;
    wdata         = rdata;
    raddr         = idx_q;

    case (state_q)
      ST_INIT: begin
        we           = 1'b1;
        waddr        = '0;
        wdata.start  = '0;
        wdata.length = AW'(ffca_pkg::HEAP_BYTES - ffca_pkg::HEADER_BYTES);
        wdata.busy   = 1'b0;
        state_d      = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d   = mode_i;
          need_d   = NW'(((32'(request_bytes_i) / ffca_pkg::PAGE_BYTES) + 1)
                         * ffca_pkg::PAGE_BYTES);
          offset_d = release_offset_i;
          idx_d    = '0;
          raddr    = '0;
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (mode_q == ffca_pkg::MODE_ALLOC) begin
          if (fit) begin
            if (split && (total_q == CW'(ffca_pkg::MAX_CHUNKS))) begin
              res_offset_d = '0;
              res_status_d = ffca_pkg::STATUS_NO_FIT;
              state_d      = ST_DONE;
            end else begin
              we           = 1'b1;
              waddr        = idx_q;
              wdata.busy   = 1'b1;
              res_offset_d = data_sum[AW-1:0];
              res_status_d = ffca_pkg::STATUS_OK;
              if (split) begin
                wdata.length = need_q[AW-1:0];
                new_start_d  = split_sum[AW-1:0];
                new_len_d    = AW'(diff - NW'(ffca_pkg::HEADER_BYTES));
                if (last) begin
                  state_d = ST_INSERT;
                end else begin
                  ptr_d   = IW'(total_q - CW'(1));
                  raddr   = IW'(total_q - CW'(1));
                  state_d = ST_SHIFT_UP;
                end
              end else begin
                state_d = ST_DONE;
              end
            end
          end else if (last) begin
            res_offset_d = '0;
            res_status_d = ffca_pkg::STATUS_NO_FIT;
            state_d      = ST_DONE;
          end else begin
            idx_d = idx_q + IW'(1);
            raddr = idx_q + IW'(1);
          end
        end else begin
          if (hit) begin
            we           = 1'b1;
            waddr        = idx_q;
            wdata.busy   = 1'b0;
            cur_start_d  = rdata.start;
            cur_len_d    = rdata.length;
            res_offset_d = '0;
            res_status_d = ffca_pkg::STATUS_OK;
            if (last) begin
              state_d = ST_DONE;
            end else begin
              raddr   = idx_q + IW'(1);
              state_d = ST_MERGE_CHK;
            end
          end else if (last) begin
            res_offset_d = '0;
            res_status_d = ffca_pkg::STATUS_BAD_OFFSET;
            state_d      = ST_DONE;
          end else begin
            idx_d = idx_q + IW'(1);
            raddr = idx_q + IW'(1);
          end
        end
      end
      ST_SHIFT_UP: begin
        we    = 1'b1;
        waddr = ptr_q + IW'(1);
        wdata = rdata;
        if (ptr_q == (idx_q + IW'(1))) begin
          state_d = ST_INSERT;
        end else begin
          ptr_d = ptr_q - IW'(1);
          raddr = ptr_q - IW'(1);
        end
      end
      ST_INSERT: begin
        we           = 1'b1;
        waddr        = idx_q + IW'(1);
        wdata.start  = new_start_q;
        wdata.length = new_len_q;
        wdata.busy   = 1'b0;
        total_d      = total_q + CW'(1);
        state_d      = ST_DONE;
      end
      ST_MERGE_CHK: begin
        if (rdata.busy) begin
          state_d = ST_DONE;
        end else begin
          we           = 1'b1;
          waddr        = idx_q;
          wdata.start  = cur_start_q;
          wdata.length = merge_sum[AW-1:0];
          wdata.busy   = 1'b0;
          if (((CW+1)'(idx_q) + (CW+1)'(2)) < (CW+1)'(total_q)) begin
            raddr   = IW'((CW+1)'(idx_q) + (CW+1)'(2));
            ptr_d   = idx_q + IW'(1);
            state_d = ST_SHIFT_DN;
          end else begin
            total_d = total_q - CW'(1);
            state_d = ST_DONE;
          end
        end
      end
      ST_SHIFT_DN: begin
        we    = 1'b1;
        waddr = ptr_q;
        wdata = rdata;
        if (((CW+1)'(ptr_q) + (CW+1)'(2)) < (CW+1)'(total_q)) begin
          raddr = IW'((CW+1)'(ptr_q) + (CW+1)'(2));
          ptr_d = ptr_q + IW'(1);
        end else begin
          total_d = total_q - CW'(1);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          data_offset_d = res_offset_q;
          status_d      = res_status_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      total_q     <= CW'(1);
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      ptr_q       <= '0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      ptr_q       <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q        <= mode_d;
    need_q        <= need_d;
    offset_q      <= offset_d;
    cur_start_q   <= cur_start_d;
    cur_len_q     <= cur_len_d;
    new_start_q   <= new_start_d;
    new_len_q     <= new_len_d;
    res_offset_q  <= res_offset_d;
    res_status_q  <= res_status_d;
    data_offset_q <= data_offset_d;
    status_q      <= status_d;
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign data_offset_o = data_offset_q;
  assign status_o      = status_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for first_fit_chunk_allocator.
// Needs ffca_pkg and the allocator RTL; predicts every result from its own
// chunk table and checks it against the block with randomized idling.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffca_pkg::*;

  localparam int RAND_ITEMS   = 1000;
  localparam int CALM_ITEMS   = 100;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 500;
  localparam int SHOW_LIMIT   = 10;

  typedef struct packed {
    logic [ADDR_W-1:0] data;
    logic [1:0]        status;
  } outcome_t;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] bytes;
    logic [ADDR_W-1:0] offset;
    outcome_t          outcome;
  } request_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              req_valid = 1'b0;
  logic              res_ready = 1'b0;
  request_t          cur_req   = '0;
  logic              req_ready;
  logic              res_valid;
  logic [ADDR_W-1:0] res_data;
  logic [1:0]        res_status;

  logic [ADDR_W-1:0] tbl_start [MAX_CHUNKS];
  logic [ADDR_W-1:0] tbl_len   [MAX_CHUNKS];
  bit                tbl_busy  [MAX_CHUNKS];
  int                tbl_count;

  request_t request_queue [$];
  outcome_t pending_outcomes [$];

  int   total       = 0;
  int   taken       = 0;
  int   got_count   = 0;
  int   fail_count  = 0;
  int   idle_cycles = 0;
  int   req_gap     = 0;
  int   stall_left  = 0;
  int   hold_left   = 0;
  bit   held        = 1'b0;
  logic req_taken   = 1'b0;

  first_fit_chunk_allocator DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (req_valid),
    .in_ready_o       (req_ready),
    .mode_i           (cur_req.mode),
    .request_bytes_i  (cur_req.bytes),
    .release_offset_i (cur_req.offset),
    .out_valid_o      (res_valid),
    .out_ready_i      (res_ready),
    .data_offset_o    (res_data),
    .status_o         (res_status)
  );

  function automatic void table_reset();
    for (int k = 0; k < MAX_CHUNKS; k++) begin
      tbl_start[k] = '0;
      tbl_len[k]   = '0;
      tbl_busy[k]  = 1'b0;
    end
    tbl_len[0] = ADDR_W'(HEAP_BYTES - HEADER_BYTES);
    tbl_count  = 1;
  endfunction

  function automatic outcome_t allocator_outcome(logic m, logic [ADDR_W-1:0] b,
                                                 logic [ADDR_W-1:0] off);
    outcome_t res;
    int       need;
    int       len;
    res = '0;
    if (m == MODE_ALLOC) begin
      need = (int'(b) / PAGE_BYTES + 1) * PAGE_BYTES;
      res.status = STATUS_NO_FIT;
      for (int i = 0; i < tbl_count; i++) begin
        len = int'(tbl_len[i]);
        if (!tbl_busy[i] && len >= need) begin
          if (len != need && len - need >= HEADER_BYTES) begin
            if (tbl_count >= MAX_CHUNKS) return res;
            for (int k = tbl_count; k > i + 1; k--) begin
              tbl_start[k] = tbl_start[k-1];
              tbl_len[k]   = tbl_len[k-1];
              tbl_busy[k]  = tbl_busy[k-1];
            end
            tbl_start[i+1] = ADDR_W'(int'(tbl_start[i]) + HEADER_BYTES + need);
            tbl_len[i+1]   = ADDR_W'(len - need - HEADER_BYTES);
            tbl_busy[i+1]  = 1'b0;
            tbl_count++;
            tbl_len[i] = ADDR_W'(need);
          end
          tbl_busy[i] = 1'b1;
          res.data   = ADDR_W'(int'(tbl_start[i]) + HEADER_BYTES);
          res.status = STATUS_OK;
          return res;
        end
      end
    end else begin
      res.status = STATUS_BAD_OFFSET;
      for (int i = 0; i < tbl_count; i++) begin
        if (int'(tbl_start[i]) + HEADER_BYTES == int'(off)) begin
          tbl_busy[i] = 1'b0;
          if (i + 1 < tbl_count && !tbl_busy[i+1]) begin
            tbl_len[i] = ADDR_W'(int'(tbl_len[i]) + int'(tbl_len[i+1]) + HEADER_BYTES);
            for (int k = i + 1; k + 1 < tbl_count; k++) begin
              tbl_start[k] = tbl_start[k+1];
              tbl_len[k]   = tbl_len[k+1];
              tbl_busy[k]  = tbl_busy[k+1];
            end
            tbl_count--;
            tbl_start[tbl_count] = '0;
            tbl_len[tbl_count]   = '0;
            tbl_busy[tbl_count]  = 1'b0;
          end
          res.status = STATUS_OK;
          return res;
        end
      end
    end
    return res;
  endfunction

  function automatic void push_request(logic m, logic [ADDR_W-1:0] b,
                                       logic [ADDR_W-1:0] off);
    request_t r;
    r.mode    = m;
    r.bytes   = b;
    r.offset  = off;
    r.outcome = allocator_outcome(m, b, off);
    request_queue.push_back(r);
  endfunction

  function automatic void push_alloc(logic [ADDR_W-1:0] b);
    push_request(MODE_ALLOC, b, ADDR_W'($urandom));
  endfunction

  function automatic void push_release(logic [ADDR_W-1:0] off);
    push_request(MODE_RELEASE, ADDR_W'($urandom), off);
  endfunction

  function automatic logic [ADDR_W-1:0] entry_offset(int i);
    return ADDR_W'(int'(tbl_start[i]) + HEADER_BYTES);
  endfunction

  function automatic int pick_entry(bit want_busy);
    int q [$];
    for (int i = 0; i < tbl_count; i++)
      if (tbl_busy[i] == want_busy) q.push_back(i);
    if (q.size() == 0) return -1;
    return q[$urandom_range(0, q.size() - 1)];
  endfunction

  function automatic void push_general_alloc();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) push_alloc(ADDR_W'($urandom));
    else if (sel < 4) push_alloc(ADDR_W'($urandom_range(0, 65535)));
    else push_alloc(ADDR_W'($urandom_range(0, 8191)));
  endfunction

  // Size a request so that its rounded need is the largest page multiple
  // that fits a chosen free chunk: exact fit, short remainder or split.
  function automatic void push_targeted_alloc();
    int idx;
    int need;
    if (!tbl_busy[tbl_count-1] && $urandom_range(0, 1) == 0) idx = tbl_count - 1;
    else idx = pick_entry(1'b0);
    if (idx < 0 || int'(tbl_len[idx]) < PAGE_BYTES) begin
      push_general_alloc();
    end else begin
      need = (int'(tbl_len[idx]) / PAGE_BYTES) * PAGE_BYTES;
      push_alloc(ADDR_W'(need - PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1)));
    end
  endfunction

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    int n_directed;
    int p;
    int n;
    int idx;
    table_reset();

    push_alloc(20'd0);
    push_alloc(20'd1023);
    push_alloc(20'd1024);
    push_alloc(20'hFFFFF);
    push_alloc(20'h7FFFF);
    push_release(20'd0);
    push_release(20'hFFFFF);
    push_release(entry_offset(1));
    push_release(entry_offset(1));
    push_alloc(20'd512);
    push_release(entry_offset(1));
    push_release(entry_offset(0));
    push_release(ADDR_W'(entry_offset(0) + 1));
    push_alloc(20'd1500);
    push_release(entry_offset(1));
    push_release(entry_offset(tbl_count - 1));
    push_release(entry_offset(tbl_count - 2));
    push_alloc(20'h55555);
    push_alloc(20'h2AAAA);
    n_directed = request_queue.size();

    while (request_queue.size() < n_directed + RAND_ITEMS) begin
      p = $urandom_range(0, 99);
      if (p < 8) begin
        n = $urandom_range(10, 60);
        repeat (n) push_alloc(ADDR_W'($urandom_range(0, 2047)));
      end else if (p < 10) begin
        for (int i = tbl_count - 1; i >= 0; i--)
          if (tbl_busy[i]) push_release(entry_offset(i));
      end else if (p < 40) begin
        push_general_alloc();
      end else if (p < 55) begin
        push_targeted_alloc();
      end else if (p < 85) begin
        idx = pick_entry(1'b1);
        if (idx < 0) push_general_alloc();
        else push_release(entry_offset(idx));
      end else if (p < 90) begin
        idx = pick_entry(1'b0);
        if (idx < 0) push_general_alloc();
        else push_release(entry_offset(idx));
      end else if (p < 95) begin
        push_release(ADDR_W'($urandom));
      end else begin
        idx = $urandom_range(0, tbl_count - 1);
        push_release(ADDR_W'(entry_offset(idx) + $urandom_range(1, HEADER_BYTES - 1)));
      end
    end
    total = request_queue.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (!(taken == total && pending_outcomes.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_outcomes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Request driver: advance to the next transfer once the current one is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!req_valid || req_taken) begin
        if (req_gap > 0) begin
          req_valid <= 1'b0;
          req_gap   <= req_gap - 1;
        end else if (request_queue.size() > 0) begin
          cur_req   <= request_queue.pop_front();
          req_valid <= 1'b1;
          if (taken < total - CALM_ITEMS && $urandom_range(0, 3) == 0)
            req_gap <= $urandom_range(1, 11);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random stall bursts, and one long hold-off after HOLD_AT results.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        res_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!held && got_count >= HOLD_AT) begin
        held      <= 1'b1;
        hold_left <= HOLD_CYCLES;
        res_ready <= 1'b0;
      end else if (stall_left > 0) begin
        res_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (got_count < total - CALM_ITEMS && $urandom_range(0, 5) == 0) begin
        res_ready  <= 1'b0;
        stall_left <= $urandom_range(0, 10);
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    bit       progress;
    req_taken <= req_valid && req_ready;
    if (rst_n) begin
      progress = 1'b0;
      if (res_valid && res_ready) begin
        progress = 1'b1;
        if (pending_outcomes.size() == 0) begin
          if (fail_count < SHOW_LIMIT)
            $display("tb: unexpected result data_offset %h status %0d", res_data, res_status);
          fail_count++;
        end else begin
          want = pending_outcomes.pop_front();
          if (want.data !== res_data || want.status !== res_status) begin
            if (fail_count < SHOW_LIMIT)
              $display("tb: result %0d: data_offset exp %h got %h, status exp %0d got %0d",
                       got_count, want.data, res_data, want.status, res_status);
            fail_count++;
          end
        end
        got_count++;
      end
      if (req_valid && req_ready) begin
        progress = 1'b1;
        pending_outcomes.push_back(cur_req.outcome);
        taken++;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule
